// ===== hw/rtl/ndbr_pkg.sv =====
// Shared types and constants of the neuron dot product, batch-norm and ReLU core.
package ndbr_pkg;
	localparam int unsigned QueueDepthDefault = 2;
	localparam int unsigned XW = 50;
	localparam int unsigned AccW = 48;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDataW = 32;
	localparam int unsigned SqrtSteps = 24;
	localparam int unsigned DivSteps = 56;

	localparam logic [CfgIdxW-1:0] REG_BIAS = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_MEAN = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_VARIANCE = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_GAIN = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_OFFSET = 3'd4;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQRT,
		ST_DIV,
		ST_MUL_HI,
		ST_MUL_LO,
		ST_FIN
	} back_state_t;

	typedef struct packed {
		logic               valid;
		logic signed [XW-1:0] x;
	} push_t;

	typedef struct packed {
		logic               empty;
		logic signed [XW-1:0] head;
	} queue_status_t;
endpackage

// ===== hw/rtl/ndbr_front.sv =====
// Front end: multiplies each pair, accumulates, and forms the biased sum on the last beat.
module ndbr_front #(
	parameter int unsigned QUEUE_DEPTH = ndbr_pkg::QueueDepthDefault
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_ready,
	input  logic signed [15:0]               feature_in,
	input  logic signed [15:0]               weight_in,
	input  logic                             last_feature,
	input  logic signed [31:0]               bias_value,
	input  logic signed [31:0]               mean_value,
	input  logic [$clog2(QUEUE_DEPTH+1)-1:0] queue_count,
	output ndbr_pkg::push_t                  push
);
	import ndbr_pkg::*;

	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	logic                  valid_s1;
	logic                  last_s1;
	logic signed [31:0]    prod_s1;
	logic [AccW-1:0]       acc_q;
	logic [CW:0]           pending;
	logic [AccW-1:0]       acc_sum;
	logic signed [XW-1:0]  x_sum;

	assign pending = {1'b0, queue_count} + {{CW{1'b0}}, (valid_s1 && last_s1)};
	assign in_ready = (pending < (CW + 1)'(QUEUE_DEPTH));

	assign acc_sum = acc_q + {{(AccW - 32){prod_s1[31]}}, prod_s1};
	assign x_sum = XW'(signed'(acc_sum)) + (XW'(bias_value) <<< 8) - (XW'(mean_value) <<< 8);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1 <= 1'b0;
			acc_q <= '0;
		end else begin
			valid_s1 <= in_valid && in_ready;
			if (in_valid && in_ready) begin
				last_s1 <= last_feature;
			end
			if (valid_s1) begin
				acc_q <= last_s1 ? '0 : acc_sum;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			prod_s1 <= feature_in * weight_in;
		end
	end

	assign push.valid = valid_s1 && last_s1;
	assign push.x = x_sum;
endmodule

// ===== hw/rtl/ndbr_queue.sv =====
// Short queue of biased sums between the front end and the normalization back end.
module ndbr_queue #(
	parameter int unsigned QUEUE_DEPTH = ndbr_pkg::QueueDepthDefault
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  ndbr_pkg::push_t                  push,
	input  logic                             pop,
	output ndbr_pkg::queue_status_t          status,
	output logic [$clog2(QUEUE_DEPTH+1)-1:0] count
);
	import ndbr_pkg::*;

	localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

	logic signed [XW-1:0] mem [QUEUE_DEPTH];
	logic [PW-1:0]        wr_q;
	logic [PW-1:0]        rd_q;
	logic [CW-1:0]        count_q;

	function automatic logic [PW-1:0] bump(input logic [PW-1:0] p);
		bump = (p == PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push.valid) begin
				wr_q <= bump(wr_q);
			end
			if (pop) begin
				rd_q <= bump(rd_q);
			end
			if (push.valid && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push.valid) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem[wr_q] <= push.x;
		end
	end

	assign status.empty = (count_q == '0);
	assign status.head = mem[rd_q];
	assign count = count_q;
endmodule

// ===== hw/rtl/ndbr_back.sv =====
// Back end: square root, division, gain multiply, offset, ReLU and saturation.
module ndbr_back (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ndbr_pkg::queue_status_t status,
	output logic                    pop,
	input  logic [30:0]             variance_value,
	input  logic signed [31:0]      gain_value,
	input  logic signed [31:0]      offset_value,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [30:0]             activation
);
	import ndbr_pkg::*;

	back_state_t state_q;
	back_state_t state_d;

	logic [47:0]  v_q;
	logic [25:0]  rem_q;
	logic [23:0]  root_q;
	logic [55:0]  d_q;
	logic [5:0]   cnt_q;
	logic         xneg_q;
	logic [55:0]  ph_q;
	logic [55:0]  pl_q;
	logic         out_valid_q;
	logic [30:0]  act_q;

	logic         gneg;
	logic [31:0]  gm;
	logic [XW-1:0] xm;
	logic [25:0]  s_rem;
	logic [25:0]  s_trial;
	logic [24:0]  d_rem;
	logic [48:0]  pm_sum;
	logic [48:0]  pm;
	logic signed [50:0] y;
	logic         out_free;
	logic         step_done;
	logic         finish;

	assign gneg = gain_value[31];
	assign gm = gneg ? (32'd0 - unsigned'(gain_value)) : unsigned'(gain_value);
	assign xm = status.head[XW-1] ? (XW'(0) - unsigned'(status.head)) : unsigned'(status.head);

	assign s_rem = {rem_q[23:0], v_q[47:46]};
	assign s_trial = {root_q, 2'b01};
	assign d_rem = {rem_q[23:0], d_q[55]};

	assign pm_sum = {1'b0, ph_q[39:0], 8'd0} + {9'd0, pl_q[55:16]};
	assign pm = ((ph_q >= 56'h100_0000_0000) || (pm_sum > 49'h1_0000_0000_0000))
		? 49'h1_0000_0000_0000 : pm_sum;
	assign y = ((xneg_q != gneg) ? (51'sd0 - signed'({2'b00, pm})) : signed'({2'b00, pm}))
		+ 51'(offset_value);

	assign out_free = !out_valid_q || out_ready;
	assign step_done = (state_q == ST_SQRT) ? (cnt_q == 6'(SqrtSteps - 1))
		: (cnt_q == 6'(DivSteps - 1));

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (!status.empty) state_d = ST_SQRT;
			end
			ST_SQRT: begin
				if (step_done) state_d = ST_DIV;
			end
			ST_DIV: begin
				if (step_done) state_d = ST_MUL_HI;
			end
			ST_MUL_HI: state_d = ST_MUL_LO;
			ST_MUL_LO: state_d = ST_FIN;
			ST_FIN: begin
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		pop = 1'b0;
		finish = 1'b0;
		case (state_q)
			ST_IDLE: pop = !status.empty;
			ST_FIN: finish = out_free;
			default: begin
				pop = 1'b0;
				finish = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_d != state_q) begin
				cnt_q <= '0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				v_q <= {({1'b0, variance_value} + 32'd1), 16'd0};
				rem_q <= '0;
				root_q <= '0;
				d_q <= {xm[47:0], 8'd0};
				xneg_q <= status.head[XW-1];
			end
			ST_SQRT: begin
				v_q <= {v_q[45:0], 2'b00};
				if (s_rem >= s_trial) begin
					root_q <= {root_q[22:0], 1'b1};
				end else begin
					root_q <= {root_q[22:0], 1'b0};
				end
				if (step_done) begin
					rem_q <= '0;
				end else if (s_rem >= s_trial) begin
					rem_q <= s_rem - s_trial;
				end else begin
					rem_q <= s_rem;
				end
			end
			ST_DIV: begin
				if (d_rem >= {1'b0, root_q}) begin
					rem_q <= {1'b0, d_rem - {1'b0, root_q}};
					d_q <= {d_q[54:0], 1'b1};
				end else begin
					rem_q <= {1'b0, d_rem};
					d_q <= {d_q[54:0], 1'b0};
				end
			end
			ST_MUL_HI: ph_q <= gm * d_q[47:24];
			ST_MUL_LO: pl_q <= gm * d_q[23:0];
			ST_FIN: begin
				if (finish) begin
					if (y <= 51'sd0) begin
						act_q <= '0;
					end else if (y > 51'sd2147483647) begin
						act_q <= 31'h7FFF_FFFF;
					end else begin
						act_q <= y[30:0];
					end
				end
			end
			default: v_q <= v_q;
		endcase
	end

	assign out_valid = out_valid_q;
	assign activation = act_q;
endmodule

// ===== hw/rtl/neuron_dot_batchnorm_relu_core.sv =====
// Top level of the neuron dot product, batch-norm and ReLU core.
// Feature and weight pairs are taken one per cycle; each pair's product is added to a
// 48-bit accumulator in the cycle after its beat. The beat marked last closes the vector,
// and its biased sum moves through a short queue to the back end, which takes one vector
// at a time: a pop, a 24-step square root of variance plus epsilon, a 56-step bit-serial
// divide, a high and a low partial multiply and a final state for offset, ReLU and
// saturation. Input beats stall only when the queue, counting a closed vector still on
// its way into it, holds as many vectors as it has entries. The user must write registers
// only while no vector is in flight; the block itself does not enforce this.
module neuron_dot_batchnorm_relu_core #(
	parameter int unsigned QUEUE_DEPTH = ndbr_pkg::QueueDepthDefault
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [ndbr_pkg::CfgIdxW-1:0]   cfg_index,
	input  logic [ndbr_pkg::CfgDataW-1:0]  cfg_data,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic signed [15:0]             feature_in,
	input  logic signed [15:0]             weight_in,
	input  logic                           last_feature,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [30:0]                    activation
);
	import ndbr_pkg::*;

	logic signed [31:0] bias_q;
	logic signed [31:0] mean_q;
	logic [30:0]        variance_q;
	logic signed [31:0] gain_q;
	logic signed [31:0] offset_q;

	push_t                             push;
	queue_status_t                     status;
	logic                              pop;
	logic [$clog2(QUEUE_DEPTH+1)-1:0]  count;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bias_q <= '0;
			mean_q <= '0;
			variance_q <= 31'd65536;
			gain_q <= 32'sd65536;
			offset_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BIAS: bias_q <= signed'(cfg_data);
				REG_MEAN: mean_q <= signed'(cfg_data);
				REG_VARIANCE: variance_q <= cfg_data[30:0];
				REG_GAIN: gain_q <= signed'(cfg_data);
				REG_OFFSET: offset_q <= signed'(cfg_data);
				default: bias_q <= bias_q;
			endcase
		end
	end

	ndbr_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.feature_in(feature_in),
		.weight_in(weight_in),
		.last_feature(last_feature),
		.bias_value(bias_q),
		.mean_value(mean_q),
		.queue_count(count),
		.push(push)
	);

	ndbr_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.pop(pop),
		.status(status),
		.count(count)
	);

	ndbr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.status(status),
		.pop(pop),
		.variance_value(variance_q),
		.gain_value(gain_q),
		.offset_value(offset_q),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.activation(activation)
	);
endmodule
